[rtl/knn_pkg.sv]
`default_nettype none
package knn_pkg;

	localparam int DIST_W  = 26;
	localparam int CFG_W   = 11;
	localparam int CFGI_W  = 2;
	localparam int INDEX_W = 10;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	localparam logic [CFGI_W-1:0] CFG_NEIGHBOUR_COUNT = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_ENTRIES_IN_USE  = 2'd1;
	localparam logic [CFGI_W-1:0] CFG_FEATURES_IN_USE = 2'd2;

	localparam logic OP_TRAIN = 1'b0;
	localparam logic OP_QUERY = 1'b1;

endpackage
`default_nettype wire

[rtl/knn_store.sv]
`default_nettype none
module knn_store #(
	parameter int T_DEPTH = 1,
	parameter int T_AW    = 1,
	parameter int Q_DEPTH = 1,
	parameter int Q_AW    = 1,
	parameter int DW      = 8
) (
	input  wire logic            clk,
	input  wire logic            twe,
	input  wire logic [T_AW-1:0] twaddr,
	input  wire logic            qwe,
	input  wire logic [Q_AW-1:0] qwaddr,
	input  wire logic [DW-1:0]   wdata,
	input  wire logic [T_AW-1:0] traddr,
	input  wire logic [Q_AW-1:0] qraddr,
	output logic      [DW-1:0]   trdata,
	output logic      [DW-1:0]   qrdata
);

	logic [DW-1:0] tmem [T_DEPTH];
	logic [DW-1:0] qmem [Q_DEPTH];

	always_ff @(posedge clk) begin
		if (twe) begin
			tmem[twaddr] <= wdata;
		end
		trdata <= tmem[traddr];
	end

	always_ff @(posedge clk) begin
		if (qwe) begin
			qmem[qwaddr] <= wdata;
		end
		qrdata <= qmem[qraddr];
	end

endmodule
`default_nettype wire

[rtl/knn_dmem.sv]
`default_nettype none
module knn_dmem #(
	parameter int DEPTH = 1,
	parameter int AW    = 1,
	parameter int DW    = 26
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[rtl/knn_nearest_search_top.sv]
`default_nettype none
// Load words (training or query features) are taken one per cycle while the search is idle.
// A word with query_last stalls the input for the search: distances are computed
// with one feature read per cycle from the store, then each of the k passes walks the
// distance memory, and a pass holds in emit while the previous result word waits.
// Reset (arst_n low) clears control, presets config; feature stores hold garbage until written.
module knn_nearest_search_top #(
	parameter int MAX_ENTRIES  = 1024,
	parameter int MAX_FEATURES = 784,
	parameter int FEATURE_BITS = 8,
	parameter int MAX_K        = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [knn_pkg::CFGI_W-1:0]      cfg_index,
	input  wire logic [knn_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            opcode,
	input  wire logic [9:0]                      entry_index,
	input  wire logic [9:0]                      feature_index,
	input  wire logic [7:0]                      feature_value,
	input  wire logic                            query_last,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [knn_pkg::INDEX_W-1:0]          neighbour_index,
	output logic [knn_pkg::DIST_W-1:0]           squared_distance,
	output logic                                 found,
	output logic                                 run_last
);

	localparam int EW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int FW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int KW    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int TDEP  = MAX_ENTRIES * MAX_FEATURES;
	localparam int TAW   = (TDEP > 1) ? $clog2(TDEP) : 1;
	localparam int DW    = knn_pkg::DIST_W;
	localparam int SQ_W  = 2 * FEATURE_BITS;
	localparam int SUM_W = ((DW > SQ_W) ? DW : SQ_W) + 1;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_DIST  = 5'b00010,
		S_DRAIN = 5'b00100,
		S_SCAN  = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t state_q;

	logic [knn_pkg::CFG_W-1:0] neighbour_count_q, entries_in_use_q, features_in_use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neighbour_count_q <= knn_pkg::CFG_W'(1);
			entries_in_use_q  <= knn_pkg::CFG_W'(1024);
			features_in_use_q <= knn_pkg::CFG_W'(784);
		end else if (cfg_we) begin
			case (cfg_index)
				knn_pkg::CFG_NEIGHBOUR_COUNT: neighbour_count_q <= cfg_data & 11'h1F;
				knn_pkg::CFG_ENTRIES_IN_USE:  entries_in_use_q  <= cfg_data;
				knn_pkg::CFG_FEATURES_IN_USE: features_in_use_q <= cfg_data & 11'h3FF;
				default: ;
			endcase
		end
	end

	// saturate config to legal counts, kept as last index
	int unsigned nk, ne, nf;
	always_comb begin
		nk = (neighbour_count_q == '0) ? 1 :
			((32'(neighbour_count_q) > MAX_K) ? MAX_K : 32'(neighbour_count_q));
		ne = (entries_in_use_q == '0) ? 1 :
			((32'(entries_in_use_q) > MAX_ENTRIES) ? MAX_ENTRIES : 32'(entries_in_use_q));
		nf = (features_in_use_q == '0) ? 1 :
			((32'(features_in_use_q) > MAX_FEATURES) ? MAX_FEATURES : 32'(features_in_use_q));
	end

	logic in_acc;
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;

	logic            twe, qwe;
	logic [TAW-1:0]  twaddr;
	logic [FW-1:0]   qwaddr;
	logic [FEATURE_BITS-1:0] wdata;

	assign twe = in_acc && opcode == knn_pkg::OP_TRAIN && 32'(entry_index) < MAX_ENTRIES
		&& 32'(feature_index) < MAX_FEATURES;
	assign qwe = in_acc && opcode == knn_pkg::OP_QUERY && 32'(feature_index) < MAX_FEATURES;
	assign twaddr = TAW'(TAW'(entry_index) * TAW'(MAX_FEATURES) + TAW'(feature_index));
	assign qwaddr = FW'(feature_index);
	assign wdata  = FEATURE_BITS'(feature_value);

	logic start;
	assign start = in_acc && opcode == knn_pkg::OP_QUERY && query_last;

	logic [EW-1:0]  ent_last_q, e_q;
	logic [FW-1:0]  feat_last_q, f_q;
	logic [KW-1:0]  k_last_q, pass_q;
	logic [TAW-1:0] base_q;

	logic [FEATURE_BITS-1:0] trd, qrd;

	knn_store #(
		.T_DEPTH(TDEP), .T_AW(TAW), .Q_DEPTH(MAX_FEATURES), .Q_AW(FW), .DW(FEATURE_BITS)
	) u_store (
		.clk(clk), .twe(twe), .twaddr(twaddr), .qwe(qwe), .qwaddr(qwaddr), .wdata(wdata),
		.traddr(TAW'(base_q + TAW'(f_q))), .qraddr(f_q), .trdata(trd), .qrdata(qrd)
	);

	// distance pipeline: s1 read data, s2 square, then accumulate
	logic           issue, v_s1, v_s2, first_s1, first_s2, last_s1, last_s2;
	logic [EW-1:0]  e_s1, e_s2;
	logic [SQ_W-1:0] sq_s2;
	logic [DW-1:0]  acc_q;
	logic [FEATURE_BITS-1:0] ad;
	logic [SUM_W-1:0] sum;
	logic [DW-1:0]  sat;
	logic           dwe;

	assign issue = (state_q == S_DIST);
	assign ad    = (qrd > trd) ? qrd - trd : trd - qrd;
	assign sum   = (first_s2 ? SUM_W'(0) : SUM_W'(acc_q)) + SUM_W'(sq_s2);
	assign sat   = (sum > SUM_W'(knn_pkg::DIST_MAX)) ? knn_pkg::DIST_MAX : DW'(sum);
	assign dwe   = v_s2 && last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (f_q == '0);
		last_s1  <= (f_q == feat_last_q);
		e_s1     <= e_q;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		e_s2     <= e_s1;
		sq_s2    <= SQ_W'(ad) * SQ_W'(ad);
		if (v_s2) begin
			acc_q <= sat;
		end
	end

	// selection scan over distance memory
	logic [EW-1:0] sc_e_q, ri_s1, best_i_q;
	logic          sc_done_q, rv_s1, rl_s1, rd_en;
	logic [DW-1:0] drd, best_q, prev_q;
	logic          found_q, have_bound_q, elig, load, out_valid_q;

	knn_dmem #(.DEPTH(MAX_ENTRIES), .AW(EW), .DW(DW)) u_dmem (
		.clk(clk), .we(dwe), .waddr(e_s2), .wdata(sat), .raddr(sc_e_q), .rdata(drd)
	);

	assign rd_en = (state_q == S_SCAN) && !sc_done_q;
	assign elig  = !have_bound_q || drd > prev_q;
	assign load  = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rv_s1        <= 1'b0;
			sc_done_q    <= 1'b0;
			found_q      <= 1'b0;
			have_bound_q <= 1'b0;
			prev_q       <= '0;
			out_valid_q  <= 1'b0;
			pass_q       <= '0;
		end else begin
			rv_s1 <= rd_en;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DIST;
					end
				end
				S_DIST: begin
					if (e_q == ent_last_q && f_q == feat_last_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q      <= S_SCAN;
						sc_done_q    <= 1'b0;
						found_q      <= 1'b0;
						have_bound_q <= 1'b0;
						pass_q       <= '0;
					end
				end
				S_SCAN: begin
					if (rd_en && sc_e_q == ent_last_q) begin
						sc_done_q <= 1'b1;
					end
					if (rv_s1 && elig && (!found_q || drd < best_q)) begin
						found_q <= 1'b1;
					end
					if (rv_s1 && rl_s1) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (load) begin
						out_valid_q <= 1'b1;
						found_q     <= 1'b0;
						sc_done_q   <= 1'b0;
						if (found_q) begin
							prev_q       <= best_q;
							have_bound_q <= 1'b1;
						end
						if (pass_q == k_last_q) begin
							state_q <= S_IDLE;
						end else begin
							pass_q  <= pass_q + 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic [knn_pkg::INDEX_W-1:0] oidx_q;
	logic [DW-1:0]               odist_q;
	logic                        ofound_q, olast_q;

	always_ff @(posedge clk) begin
		ri_s1 <= sc_e_q;
		rl_s1 <= (sc_e_q == ent_last_q);
		if (start) begin
			k_last_q    <= KW'(nk - 1);
			ent_last_q  <= EW'(ne - 1);
			feat_last_q <= FW'(nf - 1);
			e_q         <= '0;
			f_q         <= '0;
			base_q      <= '0;
		end else if (issue) begin
			if (f_q == feat_last_q) begin
				f_q    <= '0;
				e_q    <= e_q + 1'b1;
				base_q <= TAW'(base_q + TAW'(MAX_FEATURES));
			end else begin
				f_q <= f_q + 1'b1;
			end
		end
		// rewind scan address at each pass start
		if (state_q == S_DRAIN || load) begin
			sc_e_q <= '0;
		end else if (rd_en) begin
			sc_e_q <= sc_e_q + 1'b1;
		end
		if (state_q == S_SCAN && rv_s1 && elig && (!found_q || drd < best_q)) begin
			best_q   <= drd;
			best_i_q <= ri_s1;
		end
		if (load) begin
			oidx_q   <= found_q ? knn_pkg::INDEX_W'(best_i_q) : '0;
			odist_q  <= found_q ? best_q : '0;
			ofound_q <= found_q;
			olast_q  <= (pass_q == k_last_q);
		end
	end

	assign out_valid        = out_valid_q;
	assign neighbour_index  = oidx_q;
	assign squared_distance = odist_q;
	assign found            = ofound_q;
	assign run_last         = olast_q;

`ifndef NO_ASSERTIONS
	a_dwe_phase: assert property (@(posedge clk) disable iff (!arst_n)
		dwe |-> (state_q == S_DIST || state_q == S_DRAIN))
		else $error("distance write outside distance phase");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && pass_q == k_last_q) |=> state_q == S_IDLE)
		else $error("search did not end after last pass");
	a_pick_above: assert property (@(posedge clk) disable iff (!arst_n)
		(load && found_q && have_bound_q) |-> best_q > prev_q)
		else $error("pick not above previous pick");
`endif

endmodule
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;

	localparam int N_ENTRIES  = 1024;
	localparam int N_FEATURES = 784;
	localparam int TOP_K      = 16;
	localparam int QUIET_LIMIT = 40000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic       opcode;
		logic [9:0] entry_index;
		logic [9:0] feature_index;
		logic [7:0] feature_value;
		logic       query_last;
	} load_word_t;

	typedef struct packed {
		logic [knn_pkg::INDEX_W-1:0] neighbour_index;
		logic [knn_pkg::DIST_W-1:0]  squared_distance;
		logic                        found;
		logic                        run_last;
	} pick_t;

	class knn_scoreboard;
		logic [7:0]  train_mem [int];
		logic [7:0]  query_mem [int];
		logic [4:0]  k_reg = 5'd1;
		logic [10:0] entries_reg = 11'd1024;
		logic [9:0]  features_reg = 10'd784;
		logic [knn_pkg::DIST_W-1:0] last_pick = '0;
		pick_t picks_due [$];
		int errors = 0;

		function void report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endfunction

		function void set_reg(logic [knn_pkg::CFGI_W-1:0] idx, logic [knn_pkg::CFG_W-1:0] data);
			case (idx)
				knn_pkg::CFG_NEIGHBOUR_COUNT: k_reg = data[4:0];
				knn_pkg::CFG_ENTRIES_IN_USE:  entries_reg = data;
				knn_pkg::CFG_FEATURES_IN_USE: features_reg = data[9:0];
				default: ;
			endcase
		endfunction

		function int sat(int v, int hi);
			return (v < 1) ? 1 : (v > hi) ? hi : v;
		endfunction

		function logic [7:0] rd(logic [7:0] mem [int], int key);
			return mem.exists(key) ? mem[key] : 8'd0;
		endfunction

		function void note_word(load_word_t w);
			int k, n_ent, n_feat;
			logic [knn_pkg::DIST_W-1:0] entry_dist [];
			logic [31:0] sum;
			logic [knn_pkg::DIST_W-1:0] best;
			int best_idx, diff;
			bit hit, bounded;
			pick_t p;
			if (w.opcode == knn_pkg::OP_TRAIN) begin
				if (w.feature_index < N_FEATURES)
					train_mem[w.entry_index * N_FEATURES + w.feature_index] = w.feature_value;
				return;
			end
			if (w.feature_index < N_FEATURES) query_mem[w.feature_index] = w.feature_value;
			if (!w.query_last) return;
			k = sat(k_reg, TOP_K);
			n_ent = sat(entries_reg, N_ENTRIES);
			n_feat = sat(features_reg, N_FEATURES);
			entry_dist = new[n_ent];
			for (int e = 0; e < n_ent; e++) begin
				sum = 0;
				for (int f = 0; f < n_feat; f++) begin
					diff = int'(rd(query_mem, f)) - int'(rd(train_mem, e * N_FEATURES + f));
					sum += diff * diff;
				end
				entry_dist[e] = (sum > knn_pkg::DIST_MAX) ? knn_pkg::DIST_MAX :
					sum[knn_pkg::DIST_W-1:0];
			end
			bounded = 0;
			for (int pass = 0; pass < k; pass++) begin
				hit = 0;
				best = '0;
				best_idx = 0;
				for (int e = 0; e < n_ent; e++) begin
					if (bounded && entry_dist[e] <= last_pick) continue;
					if (!hit || entry_dist[e] < best) begin
						hit = 1;
						best = entry_dist[e];
						best_idx = e;
					end
				end
				if (hit) begin
					last_pick = best;
					bounded = 1;
				end
				p.neighbour_index = hit ? best_idx[knn_pkg::INDEX_W-1:0] : '0;
				p.squared_distance = hit ? best : '0;
				p.found = hit;
				p.run_last = (pass + 1 == k);
				picks_due = {picks_due, p};
			end
		endfunction

		function void check_pick(pick_t got);
			pick_t want;
			if (picks_due.size() == 0) begin
				report($sformatf("unexpected result idx=%0d dist=%0d",
					got.neighbour_index, got.squared_distance));
				return;
			end
			want = picks_due.pop_front();
			if (got.neighbour_index !== want.neighbour_index)
				report($sformatf("neighbour_index %0d, want %0d",
					got.neighbour_index, want.neighbour_index));
			if (got.squared_distance !== want.squared_distance)
				report($sformatf("squared_distance %0d, want %0d",
					got.squared_distance, want.squared_distance));
			if (got.found !== want.found)
				report($sformatf("found %0b, want %0b", got.found, want.found));
			if (got.run_last !== want.run_last)
				report($sformatf("run_last %0b, want %0b", got.run_last, want.run_last));
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [knn_pkg::CFGI_W-1:0] cfg_index = '0;
	logic [knn_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic opcode = 0;
	logic [9:0] entry_index = '0;
	logic [9:0] feature_index = '0;
	logic [7:0] feature_value = '0;
	logic query_last = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [knn_pkg::INDEX_W-1:0] neighbour_index;
	logic [knn_pkg::DIST_W-1:0] squared_distance;
	logic found;
	logic run_last;

	knn_scoreboard sb = new();
	int send_idle_pct = 37;
	int recv_idle_pct = 73;
	int hold_requests = 0;
	int words_sent = 0;

	knn_nearest_search_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .entry_index(entry_index), .feature_index(feature_index),
		.feature_value(feature_value), .query_last(query_last),
		.out_valid(out_valid), .out_ready(out_ready),
		.neighbour_index(neighbour_index), .squared_distance(squared_distance),
		.found(found), .run_last(run_last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Receiver: random stalls, plus long hold-offs on request.
	initial begin
		int hold_left;
		int served;
		hold_left = 0;
		served = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (served != hold_requests) begin
				served = hold_requests;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_pick({neighbour_index, squared_distance, found, run_last});
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic send_word(logic op, int ent, int feat, int val, logic last);
		load_word_t w;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		w = {op, ent[9:0], feat[9:0], val[7:0], last};
		in_valid <= 1'b1;
		opcode <= w.opcode;
		entry_index <= w.entry_index;
		feature_index <= w.feature_index;
		feature_value <= w.feature_value;
		query_last <= w.query_last;
		do @(posedge clk); while (!in_ready);
		sb.note_word(w);
		words_sent++;
	endtask

	// Drop valid and wait until every pick has come back and the search has settled.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.picks_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_config(int k, int ents, int feats);
		int vals [3];
		logic [knn_pkg::CFGI_W-1:0] idx [3];
		vals = '{k, ents, feats};
		idx = '{knn_pkg::CFG_NEIGHBOUR_COUNT, knn_pkg::CFG_ENTRIES_IN_USE,
			knn_pkg::CFG_FEATURES_IN_USE};
		for (int i = 0; i < 3; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i][knn_pkg::CFG_W-1:0];
			@(posedge clk);
			sb.set_reg(idx[i], vals[i][knn_pkg::CFG_W-1:0]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Fill entries and query for one search; narrow values make ties likely.
	task automatic run_search(int ents, int feats, bit noisy);
		int narrow;
		narrow = ($urandom_range(3) == 0);
		for (int e = 0; e < ents; e++)
			for (int f = 0; f < feats; f++) begin
				send_word(knn_pkg::OP_TRAIN, e, f,
					narrow ? $urandom_range(2) : $urandom_range(255), $urandom_range(1));
				if (noisy && $urandom_range(9) == 0)
					send_word($urandom_range(1), $urandom_range(1023),
						$urandom_range(N_FEATURES, 1023), $urandom_range(255), 1'b0);
			end
		for (int f = 0; f < feats; f++)
			send_word(knn_pkg::OP_QUERY, $urandom_range(1023), f,
				narrow ? $urandom_range(2) : $urandom_range(255), f == feats - 1);
	endtask

	initial begin
		int ents, feats, reps;
		bit first;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, out-of-range writes, tied distances.
		set_config(31, 2, 2);
		send_word(knn_pkg::OP_TRAIN, 0, 0, 0, 1'b0);
		send_word(knn_pkg::OP_TRAIN, 0, 1, 255, 1'b1);
		send_word(knn_pkg::OP_TRAIN, 1, 0, 255, 1'b0);
		send_word(knn_pkg::OP_TRAIN, 1, 1, 0, 1'b0);
		send_word(knn_pkg::OP_TRAIN, 1023, 1023, 255, 1'b1);
		send_word(knn_pkg::OP_TRAIN, 1023, 783, 170, 1'b0);
		send_word(knn_pkg::OP_QUERY, 0, 1023, 85, 1'b0);
		send_word(knn_pkg::OP_QUERY, 1023, 0, 255, 1'b0);
		send_word(knn_pkg::OP_QUERY, 682, 1, 255, 1'b1);
		drain();
		set_config(0, 3, 1);
		send_word(knn_pkg::OP_TRAIN, 2, 0, 255, 1'b0);
		send_word(knn_pkg::OP_QUERY, 341, 0, 0, 1'b1);
		send_word(knn_pkg::OP_QUERY, 0, 1023, 7, 1'b1);
		drain();

		// Random searches; first batch runs under a long receiver hold-off.
		words_sent = 0;
		first = 1;
		hold_requests++;
		while (words_sent < 100) begin
			if (words_sent >= 33) begin
				send_idle_pct = 73;
				recv_idle_pct = 37;
			end
			if (words_sent >= 66) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			ents = $urandom_range(1, 4);
			feats = $urandom_range(1, 3);
			set_config($urandom_range(0, 31), ents, feats);
			reps = first ? 2 : $urandom_range(1, 3);
			first = 0;
			for (int r = 0; r < reps; r++)
				run_search(ents, feats, 1'b1);
			drain();
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

[sim.f]
rtl/knn_pkg.sv
rtl/knn_store.sv
rtl/knn_dmem.sv
rtl/knn_nearest_search_top.sv
sim/tb.sv
